### rtl/csc_pkg.sv
package csc_pkg;

	localparam int ROW_CFG_W  = 11;
	localparam int COL_CFG_W  = 6;
	localparam int THR_W      = 19;
	localparam int CFG_DATA_W = 19;
	localparam int CFG_IDX_W  = 2;
	localparam int ENERGY_W   = 16;
	localparam int COUNT_W    = 16;

	localparam int TAP_CENTER = 0;
	localparam int TAP_UP     = 1;
	localparam int TAP_DOWN   = 2;
	localparam int TAP_LEFT   = 3;
	localparam int TAP_RIGHT  = 4;
	localparam int TAP_COUNT  = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT    = 2'd0,
		REG_COLUMN_COUNT = 2'd1,
		REG_THRESHOLD    = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic active;
		logic up;
		logic down;
		logic left;
		logic right;
	} nbr_mask_t;

endpackage

### rtl/csc_cell.sv
module csc_cell #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         shift,
	input  logic         inject,
	input  logic [W-1:0] fresh,
	input  logic [W-1:0] from_next,
	output logic [W-1:0] value
);

	logic [W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= inject ? fresh : from_next;
		end
	end

	assign value = value_q;

endmodule

### rtl/csc_judge.sv
module csc_judge import csc_pkg::*; #(
	parameter int PIXEL_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 advance,
	input  logic [TAP_COUNT-1:0][PIXEL_BITS-1:0] taps,
	input  nbr_mask_t                            mask,
	input  logic signed [THR_W-1:0]              threshold,
	output logic                                 hit
);

	localparam int SUM_W = PIXEL_BITS + 3;
	localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

	logic [TAP_COUNT-1:0][PIXEL_BITS-1:0] taps_s1;
	nbr_mask_t                            mask_s1;
	logic signed [SUM_W-1:0]              sum_d;
	logic signed [SUM_W-1:0]              sum_s2;
	logic                                 active_s2;
	logic                                 hit_s3;

	always_comb begin
		sum_d = SUM_W'(signed'(taps_s1[TAP_CENTER]));
		if (mask_s1.up) begin
			sum_d = sum_d + SUM_W'(signed'(taps_s1[TAP_UP]));
		end
		if (mask_s1.down) begin
			sum_d = sum_d + SUM_W'(signed'(taps_s1[TAP_DOWN]));
		end
		if (mask_s1.left) begin
			sum_d = sum_d + SUM_W'(signed'(taps_s1[TAP_LEFT]));
		end
		if (mask_s1.right) begin
			sum_d = sum_d + SUM_W'(signed'(taps_s1[TAP_RIGHT]));
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			taps_s1   <= taps;
			mask_s1   <= mask;
			sum_s2    <= sum_d;
			active_s2 <= mask_s1.active;
			hit_s3    <= active_s2 && (CMP_W'(sum_s2) > CMP_W'(threshold));
		end
	end

	assign hit = hit_s3;

endmodule

### rtl/cross_stencil_threshold_count.sv
// Counts, per frame of a row-major grid, the cells whose five-point cross sum (cell plus its
// in-grid up, down, left and right neighbours) is strictly greater than the threshold, and
// delivers the count as one transaction after the last value of the frame. One value is taken
// every clock unless input is stalled; the count is registered once the last value has passed
// the judge stages. Two rows of MAX_COLS delay cells act as the line store, and three judging
// lanes (the row above, the last row and the final cell) each run a three-stage sum and
// compare. Input is stalled only while a finished count still waits at the output and the
// next frame's count reaches it. Row, column and threshold writes restart the frame.
module cross_stencil_threshold_count import csc_pkg::*; #(
	parameter int MAX_COLS   = 32,
	parameter int MAX_ROWS   = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [ENERGY_W-1:0]   energy,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COUNT_W-1:0]    burst_count
);

	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W = $clog2(MAX_COLS);

	logic [ROW_W-1:0]       rows_last_q;
	logic [COL_W-1:0]       cols_last_q;
	logic signed [THR_W-1:0] thr_q;
	logic [ROW_W-1:0]       row_q;
	logic [COL_W-1:0]       col_q;
	logic [COUNT_W-1:0]     count_q;
	logic [PIXEL_BITS-1:0]  prev1_q;
	logic [PIXEL_BITS-1:0]  prev2_q;
	logic [PIXEL_BITS-1:0]  left_q;
	logic                   out_valid_q;
	logic [COUNT_W-1:0]     burst_count_q;

	logic v_s1, v_s2, v_s3;
	logic last_s1, last_s2, last_s3;

	logic                  cfg_wr;
	reg_index_t            idx;
	logic                  wr_rows, wr_cols, wr_thr, cfg_restart;
	logic [ROW_W-1:0]      rows_last_d;
	logic [COL_W-1:0]      cols_last_d;
	logic [ROW_CFG_W-1:0]  rows_cfg;
	logic [COL_CFG_W-1:0]  cols_cfg;

	logic                  hold;
	logic                  in_accept;
	logic                  push;
	logic [PIXEL_BITS-1:0] px;
	logic                  first_row, last_row, first_col, last_col, frame_end;

	logic [MAX_COLS-1:0][PIXEL_BITS-1:0] row_a;
	logic [MAX_COLS-1:0][PIXEL_BITS-1:0] row_b;

	logic [TAP_COUNT-1:0][PIXEL_BITS-1:0] taps_x, taps_y, taps_z;
	nbr_mask_t                            mask_x, mask_y, mask_z;
	logic                                 hit_x, hit_y, hit_z;
	logic [1:0]                           hits_s3;
	logic [COUNT_W:0]                     count_sum;
	logic [COUNT_W-1:0]                   count_sat;

	// Configuration decode and clamping of the grid dimensions.
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign idx       = reg_index_t'(cfg_index);
	assign rows_cfg  = cfg_data[ROW_CFG_W-1:0];
	assign cols_cfg  = cfg_data[COL_CFG_W-1:0];

	always_comb begin
		wr_rows = 1'b0;
		wr_cols = 1'b0;
		wr_thr  = 1'b0;
		unique case (idx)
			REG_ROW_COUNT:    wr_rows = cfg_wr;
			REG_COLUMN_COUNT: wr_cols = cfg_wr;
			REG_THRESHOLD:    wr_thr  = cfg_wr;
			default:          wr_thr  = 1'b0;
		endcase
	end

	assign cfg_restart = wr_rows || wr_cols || wr_thr;

	always_comb begin
		if (rows_cfg == '0) begin
			rows_last_d = '0;
		end else if (32'(rows_cfg) > MAX_ROWS) begin
			rows_last_d = ROW_W'(MAX_ROWS - 1);
		end else begin
			rows_last_d = ROW_W'(32'(rows_cfg) - 32'd1);
		end
		if (cols_cfg == '0) begin
			cols_last_d = '0;
		end else if (32'(cols_cfg) > MAX_COLS) begin
			cols_last_d = COL_W'(MAX_COLS - 1);
		end else begin
			cols_last_d = COL_W'(32'(cols_cfg) - 32'd1);
		end
	end

	// Handshake and position within the frame.
	assign hold      = v_s3 && last_s3 && out_valid_q && out_stall;
	assign in_stall  = hold;
	assign in_accept = in_valid && !in_stall;
	assign push      = v_s3 && last_s3 && !hold;
	assign px        = PIXEL_BITS'(energy);

	assign first_row = (row_q == '0);
	assign last_row  = (row_q == rows_last_q);
	assign first_col = (col_q == '0);
	assign last_col  = (col_q == cols_last_q);
	assign frame_end = last_row && last_col;

	// Two rows of delay cells; each row delays by the configured column count.
	for (genvar i = 0; i < MAX_COLS; i++) begin : g_line
		logic [PIXEL_BITS-1:0] next_a;
		logic [PIXEL_BITS-1:0] next_b;
		if (i == MAX_COLS - 1) begin : g_tail
			assign next_a = px;
			assign next_b = row_a[0];
		end else begin : g_body
			assign next_a = row_a[i+1];
			assign next_b = row_b[i+1];
		end

		csc_cell #(.W(PIXEL_BITS)) u_cell_a (
			.clk       (clk),
			.shift     (in_accept),
			.inject    (cols_last_q == COL_W'(i)),
			.fresh     (px),
			.from_next (next_a),
			.value     (row_a[i])
		);

		csc_cell #(.W(PIXEL_BITS)) u_cell_b (
			.clk       (clk),
			.shift     (in_accept),
			.inject    (cols_last_q == COL_W'(i)),
			.fresh     (row_a[0]),
			.from_next (next_b),
			.value     (row_b[i])
		);
	end

	// Lane X judges the cell above the new value, lane Y the cell to its left in the
	// last row, and lane Z the final cell of the frame.
	always_comb begin
		taps_x[TAP_CENTER] = row_a[0];
		taps_x[TAP_UP]     = row_b[0];
		taps_x[TAP_DOWN]   = px;
		taps_x[TAP_LEFT]   = left_q;
		taps_x[TAP_RIGHT]  = row_a[1];
		mask_x.active      = !first_row;
		mask_x.up          = (row_q > ROW_W'(1));
		mask_x.down        = 1'b1;
		mask_x.left        = !first_col;
		mask_x.right       = !last_col;

		taps_y[TAP_CENTER] = prev1_q;
		taps_y[TAP_UP]     = left_q;
		taps_y[TAP_DOWN]   = '0;
		taps_y[TAP_LEFT]   = prev2_q;
		taps_y[TAP_RIGHT]  = px;
		mask_y.active      = last_row && !first_col;
		mask_y.up          = !first_row;
		mask_y.down        = 1'b0;
		mask_y.left        = (col_q > COL_W'(1));
		mask_y.right       = 1'b1;

		taps_z[TAP_CENTER] = px;
		taps_z[TAP_UP]     = row_a[0];
		taps_z[TAP_DOWN]   = '0;
		taps_z[TAP_LEFT]   = prev1_q;
		taps_z[TAP_RIGHT]  = '0;
		mask_z.active      = frame_end;
		mask_z.up          = !first_row;
		mask_z.down        = 1'b0;
		mask_z.left        = !first_col;
		mask_z.right       = 1'b0;
	end

	csc_judge #(.PIXEL_BITS(PIXEL_BITS)) u_judge_x (
		.clk       (clk),
		.advance   (!hold),
		.taps      (taps_x),
		.mask      (mask_x),
		.threshold (thr_q),
		.hit       (hit_x)
	);

	csc_judge #(.PIXEL_BITS(PIXEL_BITS)) u_judge_y (
		.clk       (clk),
		.advance   (!hold),
		.taps      (taps_y),
		.mask      (mask_y),
		.threshold (thr_q),
		.hit       (hit_y)
	);

	csc_judge #(.PIXEL_BITS(PIXEL_BITS)) u_judge_z (
		.clk       (clk),
		.advance   (!hold),
		.taps      (taps_z),
		.mask      (mask_z),
		.threshold (thr_q),
		.hit       (hit_z)
	);

	assign hits_s3   = 2'(hit_x) + 2'(hit_y) + 2'(hit_z);
	assign count_sum = {1'b0, count_q} + (COUNT_W + 1)'(hits_s3);
	assign count_sat = count_sum[COUNT_W] ? '1 : count_sum[COUNT_W-1:0];

	always_ff @(posedge clk) begin
		if (in_accept) begin
			prev1_q <= px;
			prev2_q <= prev1_q;
			left_q  <= row_a[0];
		end
		if (push) begin
			burst_count_q <= count_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_last_q <= '0;
			cols_last_q <= '0;
			thr_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			count_q     <= '0;
		end else begin
			if (wr_rows) begin
				rows_last_q <= rows_last_d;
			end
			if (wr_cols) begin
				cols_last_q <= cols_last_d;
			end
			if (wr_thr) begin
				thr_q <= signed'(cfg_data[THR_W-1:0]);
			end
			if (cfg_restart) begin
				row_q   <= '0;
				col_q   <= '0;
				count_q <= '0;
			end else begin
				if (in_accept) begin
					if (last_col) begin
						col_q <= '0;
						row_q <= last_row ? '0 : row_q + ROW_W'(1);
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
				if (v_s3 && !hold) begin
					count_q <= last_s3 ? '0 : count_sat;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			last_s1     <= 1'b0;
			last_s2     <= 1'b0;
			last_s3     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!hold) begin
				v_s1    <= in_accept;
				last_s1 <= frame_end;
				v_s2    <= v_s1;
				last_s2 <= last_s1;
				v_s3    <= v_s2;
				last_s3 <= last_s2;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign burst_count = burst_count_q;

	a_position_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= rows_last_q) && (col_q <= cols_last_q))
		else $error("Frame position lies outside the configured grid.");

	a_frame_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && frame_end && !cfg_restart |=> (row_q == '0) && (col_q == '0))
		else $error("Frame position did not return to the origin after the last value.");

	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (count_q == '0))
		else $error("Running count not cleared after the frame result.");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s3 && last_s3))
		else $error("Result transaction raised without a finished frame.");

endmodule

### bench/burst_count_checker.sv
`timescale 1ns / 1ps

module burst_count_checker import csc_pkg::*; #(
	parameter int MAX_COLS = 32,
	parameter int MAX_ROWS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [ENERGY_W-1:0]   energy,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [COUNT_W-1:0]    burst_count,
	output int                    counts_owed,
	output int                    mismatches
);

	logic [ROW_CFG_W-1:0]       row_setting;
	logic [COL_CFG_W-1:0]       col_setting;
	logic signed [THR_W-1:0]    threshold_setting;
	int                         row_pos;
	int                         col_pos;
	logic signed [ENERGY_W-1:0] grid [MAX_ROWS][MAX_COLS];
	logic [COUNT_W-1:0]         expected_counts [$];
	logic [COUNT_W-1:0]         want;

	function automatic int frame_rows();
		if (row_setting == 0) return 1;
		if (row_setting > MAX_ROWS) return MAX_ROWS;
		return int'(row_setting);
	endfunction

	function automatic int frame_cols();
		if (col_setting == 0) return 1;
		if (col_setting > MAX_COLS) return MAX_COLS;
		return int'(col_setting);
	endfunction

	// Cells outside the grid simply drop out of the cross.
	function automatic int cross_sum(input int r, input int c, input int rows, input int cols);
		int total;
		total = grid[r][c];
		if (r > 0) total += grid[r-1][c];
		if (r + 1 < rows) total += grid[r+1][c];
		if (c > 0) total += grid[r][c-1];
		if (c + 1 < cols) total += grid[r][c+1];
		return total;
	endfunction

	function automatic logic [COUNT_W-1:0] frame_count(input int rows, input int cols);
		int hits;
		hits = 0;
		for (int r = 0; r < rows; r++) begin
			for (int c = 0; c < cols; c++) begin
				if (cross_sum(r, c, rows, cols) > int'(threshold_setting) && hits < 65535)
					hits++;
			end
		end
		return COUNT_W'(hits);
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: burst_count mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// Writes to the unused index leave the frame where it is.
	task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_ROW_COUNT: begin
				row_setting = data[ROW_CFG_W-1:0];
			end
			REG_COLUMN_COUNT: begin
				col_setting = data[COL_CFG_W-1:0];
			end
			REG_THRESHOLD: begin
				threshold_setting = data[THR_W-1:0];
			end
			default: begin
				return;
			end
		endcase
		row_pos = 0;
		col_pos = 0;
	endtask

	task automatic take_energy(input logic signed [ENERGY_W-1:0] px);
		int rows;
		int cols;
		rows = frame_rows();
		cols = frame_cols();
		grid[row_pos][col_pos] = px;
		if (row_pos + 1 == rows && col_pos + 1 == cols) begin
			expected_counts.push_back(frame_count(rows, cols));
			row_pos = 0;
			col_pos = 0;
		end else if (col_pos + 1 == cols) begin
			col_pos = 0;
			row_pos++;
		end else begin
			col_pos++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_setting = 1;
			col_setting = 1;
			threshold_setting = 0;
			row_pos = 0;
			col_pos = 0;
			expected_counts.delete();
			mismatches = 0;
			counts_owed <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_write(cfg_index, cfg_data);
			if (out_valid && !out_stall) begin
				if (expected_counts.size() == 0) begin
					report_mismatch($sformatf("count %0d with no frame finished", burst_count));
				end else begin
					want = expected_counts.pop_front();
					if (burst_count !== want)
						report_mismatch($sformatf("got %0d, expected %0d", burst_count, want));
				end
			end
			if (in_valid && !in_stall)
				take_energy(energy);
			counts_owed <= expected_counts.size();
		end
	end

endmodule

### bench/tb_cross_stencil_threshold_count.sv
`timescale 1ns / 1ps

module tb_cross_stencil_threshold_count;
	import csc_pkg::*;

	localparam int MAX_COLS      = 32;
	localparam int MAX_ROWS      = 1024;
	localparam int LONG_HOLD     = 200;
	localparam int SETTLE_CYCLES = 8;
	localparam int STYLE_WIDE    = 0;
	localparam int STYLE_NARROW  = 1;
	localparam int STYLE_EXTREME = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam logic [12*ENERGY_W-1:0] CORNER_VALUES = {
		16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000, 16'h7FFF,
		16'h7FFF, 16'h8000, 16'h8000, 16'h4000, 16'hC000, 16'h0002
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [ENERGY_W-1:0]   energy;
	logic                  out_valid;
	logic                  out_stall;
	logic [COUNT_W-1:0]    burst_count;
	int                    counts_owed;
	int                    mismatches;

	bit quiet;
	bit hold_ask;
	bit rx_stalling;
	int rx_left;
	int tx_left;
	int frame_cells;
	int sent_items;
	int frames_sent;

	cross_stencil_threshold_count uut (.*);

	burst_count_checker count_check (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("cross_stencil_threshold_count verification failed");
		$finish;
	end

	// Output side: random stall bursts, and one long hold-off on request.
	initial begin
		out_stall <= 1'b0;
		rx_left = 0;
		rx_stalling = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask) begin
				hold_ask = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (rx_left == 0) begin
					rx_stalling = $urandom_range(0, 2) == 0;
					rx_left = rx_stalling ? $urandom_range(1, 9) : $urandom_range(1, 30);
				end
				rx_left--;
				out_stall <= rx_stalling && !quiet;
			end
		end
	end

	function automatic logic [ENERGY_W-1:0] next_energy(input int style);
		case (style)
			STYLE_WIDE: begin
				return ENERGY_W'($urandom);
			end
			STYLE_NARROW: begin
				return ENERGY_W'($urandom_range(0, 16) - 8);
			end
			default: begin
				case ($urandom_range(0, 4))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					3: return 16'hFFFF;
					default: return 16'h0001;
				endcase
			end
		endcase
	endfunction

	function automatic int random_threshold(input int style);
		if (style == STYLE_NARROW || $urandom_range(0, 3) == 0)
			return int'($urandom_range(0, 40)) - 20;
		return int'($urandom_range(0, 327675)) - 163840;
	endfunction

	task automatic send_energy(input logic [ENERGY_W-1:0] value);
		if (tx_left == 0) begin
			tx_left = $urandom_range(1, 30);
			if (!quiet && $urandom_range(0, 2) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
		end
		tx_left--;
		in_valid <= 1'b1;
		energy <= value;
		do @(posedge clk); while (in_stall);
		sent_items++;
	endtask

	task automatic send_frame(input int style);
		for (int i = 0; i < frame_cells; i++)
			send_energy(next_energy(style));
		frames_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (counts_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic end_writes();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Unused upper bits of the dimension writes carry random junk.
	task automatic configure(input int rows, input int cols, input int thr);
		logic [31:0] junk;
		int eff_rows;
		int eff_cols;
		junk = $urandom;
		write_reg(REG_ROW_COUNT, {junk[CFG_DATA_W-ROW_CFG_W-1:0], ROW_CFG_W'(rows)});
		write_reg(REG_COLUMN_COUNT,
			{junk[31:32-(CFG_DATA_W-COL_CFG_W)], COL_CFG_W'(cols)});
		write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
		end_writes();
		eff_rows = rows < 1 ? 1 : (rows > MAX_ROWS ? MAX_ROWS : rows);
		eff_cols = cols < 1 ? 1 : (cols > MAX_COLS ? MAX_COLS : cols);
		frame_cells = eff_rows * eff_cols;
	endtask

	initial begin
		int style;
		int rows;
		int cols;
		int frames;
		int part;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_ROW_COUNT;
		cfg_data <= '0;
		in_valid <= 1'b0;
		energy <= '0;
		quiet = 1'b0;
		hold_ask = 1'b0;
		tx_left = 0;
		sent_items = 0;
		frames_sent = 0;
		frame_cells = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset the grid is a single cell with a threshold of zero.
		send_energy(16'h7FFF);
		send_energy(16'h8000);
		send_energy(16'h0000);
		send_energy(16'h0001);
		drain();

		// A write to the unused index mid-frame must not restart the frame.
		configure(3, 4, 0);
		for (int i = 0; i < 12; i++) begin
			if (i == 5) begin
				drain();
				write_reg(REG_SPARE, '1);
				end_writes();
			end
			send_energy(CORNER_VALUES[(11 - i) * ENERGY_W +: ENERGY_W]);
		end
		for (int i = 0; i < 6; i++)
			send_energy(next_energy(STYLE_EXTREME));
		drain();

		// Zero dimensions clamp up, oversized ones clamp down.
		configure(0, 0, 163835);
		for (int i = 0; i < 3; i++)
			send_frame(STYLE_EXTREME);
		drain();
		configure(2, 63, -163840);
		send_frame(STYLE_EXTREME);
		send_frame(STYLE_WIDE);
		drain();

		// Single-cell frames against a long output hold-off fill the block up.
		configure(1, 1, 0);
		hold_ask = 1'b1;
		for (int i = 0; i < 40; i++)
			send_frame(STYLE_WIDE);
		drain();

		while (sent_items < 700 || frames_sent < 60) begin
			style = $urandom_range(0, 2);
			rows = $urandom_range(0, 7) == 0 ? $urandom_range(0, 12) : $urandom_range(1, 3);
			cols = $urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : $urandom_range(1, 6);
			configure(rows, cols, random_threshold(style));
			frames = $urandom_range(1, 4);
			for (int f = 0; f < frames; f++) begin
				if (frame_cells > 1 && $urandom_range(0, 9) == 0) begin
					part = $urandom_range(1, frame_cells - 1);
					for (int i = 0; i < part; i++)
						send_energy(next_energy(style));
					break;
				end
				send_frame(style);
			end
			drain();
			if ($urandom_range(0, 5) == 0) begin
				write_reg(REG_SPARE, CFG_DATA_W'($urandom));
				end_writes();
			end
		end

		quiet = 1'b1;
		configure(3, 63, -163840);
		send_frame(STYLE_WIDE);
		drain();
		configure(6, 1, random_threshold(STYLE_WIDE));
		send_frame(STYLE_WIDE);
		drain();

		if (mismatches == 0) begin
			$display("cross_stencil_threshold_count verification clean");
		end else begin
			$display("cross_stencil_threshold_count verification failed");
		end
		$finish;
	end

endmodule

### files.f
rtl/csc_pkg.sv
rtl/csc_cell.sv
rtl/csc_judge.sv
rtl/cross_stencil_threshold_count.sv
bench/burst_count_checker.sv
bench/tb_cross_stencil_threshold_count.sv
